FILE: hdl/dq_pkg.sv
package dq_pkg;

    // word width of the stored items
    localparam int WORD_W = 32;

    // default number of entries in the ring
    localparam int DEPTH_DEF = 1024;

    // request codes
    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_BACK  = 3'd4,
        OP_PEEK_FRONT = 3'd5,
        OP_SIZE       = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // result description handed from the pointer logic to the output stage
    typedef struct packed {
        status_t             status;
        logic                use_mem;
        logic [WORD_W-1:0]   imm_data;
    } res_info_t;

endpackage

FILE: hdl/double_ended_queue_core.sv
// Bounded double-ended queue of signed 32-bit words held in a ring of DEPTH
// entries in a synchronous dual-port memory. Each item on the input channel
// carries one request (push or pop at either end, peek at either end, size,
// clear) and yields exactly one result item: a status (ok, empty, full), a
// data word (popped or peeked word, the occupancy for size, zero otherwise)
// and the occupancy after the request. Pops and peeks on an empty queue and
// pushes on a full queue report an error and leave the queue unchanged.
// One item can be taken every cycle while the result side takes results;
// each result passes through a pending stage, which waits for the memory
// read, and an output register, so that a stalled result does not stop the
// next request from entering. No clearing pass is needed after reset: only
// entries that were written are ever read.
module double_ended_queue_core #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          func,
    input  logic signed [dq_pkg::WORD_W-1:0]    value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic signed [dq_pkg::WORD_W-1:0]    data,
    output logic [$clog2(DEPTH + 1)-1:0]        count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // handshake
    logic accept;
    logic out_load;

    // memory ports
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [dq_pkg::WORD_W-1:0] wr_data;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [dq_pkg::WORD_W-1:0] rd_data;

    // result description for the item just accepted
    dq_pkg::res_info_t info;
    logic [CW-1:0]     count_next;

    // pending stage: holds the item while the memory read is registered
    logic              pend_valid_reg;
    dq_pkg::res_info_t pend_info_reg;
    logic [CW-1:0]     pend_count_reg;

    // output register
    logic                      out_valid_reg;
    dq_pkg::status_t           status_reg;
    logic [dq_pkg::WORD_W-1:0] data_reg;
    logic [CW-1:0]             count_reg;

    // the pending item moves on whenever the output register is free or
    // being emptied, which in turn frees the pending stage for a new item
    assign out_load = pend_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !pend_valid_reg || out_load;
    assign accept   = in_valid && in_ready;

    // head and occupancy, request decode, ring addressing
    dq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .func       (dq_pkg::op_t'(func)),
        .value      (value),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .info       (info),
        .count_next (count_next)
    );

    // word storage; a write and a later read of the same entry always fall
    // on different edges, so no forwarding path is required
    dq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // control state of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload of both stages
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_info_reg  <= info;
            pend_count_reg <= count_next;
        end
        if (out_load)
        begin
            status_reg <= pend_info_reg.status;
            data_reg   <= pend_info_reg.use_mem ? rd_data : pend_info_reg.imm_data;
            count_reg  <= pend_count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign count     = count_reg;

`ifndef ASSERT_OFF
    a_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pend_valid_reg)
        else $error("accepted item not held in pending stage");
`endif

endmodule

FILE: hdl/dq_ram.sv
module dq_ram #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [dq_pkg::WORD_W-1:0]                  wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [dq_pkg::WORD_W-1:0]                  rd_data
);

    logic [dq_pkg::WORD_W-1:0] mem [DEPTH];
    logic [dq_pkg::WORD_W-1:0] rd_data_reg;

    // simple dual port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/dq_ctrl.sv
module dq_ctrl #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         accept,
    input  dq_pkg::op_t                                  func,
    input  logic [dq_pkg::WORD_W-1:0]                    value,
    output logic                                         wr_en,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    output logic [dq_pkg::WORD_W-1:0]                    wr_data,
    output logic                                         rd_en,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output dq_pkg::res_info_t                            info,
    output logic [$clog2(DEPTH + 1)-1:0]                 count_next
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;

    logic [SW-1:0] tail_sum;
    logic [SW-1:0] last_sum;
    logic [AW-1:0] tail_addr;
    logic [AW-1:0] last_addr;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] head_dec;
    logic          full;
    logic          empty;

    // ring positions, each wrapped by one compare
    always_comb
    begin
        tail_sum  = SW'(head_reg) + SW'(occ_reg);
        last_sum  = tail_sum - SW'(1);
        tail_addr = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
        last_addr = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);
        head_inc  = (head_reg == LAST_A) ? '0 : head_reg + AW'(1);
        head_dec  = (head_reg == '0) ? LAST_A : head_reg - AW'(1);
        full      = (occ_reg == DEPTH_C);
        empty     = (occ_reg == '0);
    end

    always_comb
    begin
        head_next     = head_reg;
        occ_next      = occ_reg;
        wr_en         = 1'b0;
        wr_addr       = tail_addr;
        wr_data       = value;
        rd_en         = 1'b0;
        rd_addr       = head_reg;
        info.status   = dq_pkg::ST_OK;
        info.use_mem  = 1'b0;
        info.imm_data = '0;
        case (func)
            dq_pkg::OP_PUSH_BACK:
            begin
                if (full)
                begin
                    info.status = dq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en    = accept;
                    occ_next = occ_reg + CW'(1);
                end
            end
            dq_pkg::OP_PUSH_FRONT:
            begin
                wr_addr = head_dec;
                if (full)
                begin
                    info.status = dq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en     = accept;
                    head_next = head_dec;
                    occ_next  = occ_reg + CW'(1);
                end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_PEEK_FRONT:
            begin
                if (empty)
                begin
                    info.status = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en        = accept;
                    info.use_mem = 1'b1;
                    if (func == dq_pkg::OP_POP_FRONT)
                    begin
                        head_next = head_inc;
                        occ_next  = occ_reg - CW'(1);
                    end
                end
            end
            dq_pkg::OP_POP_BACK, dq_pkg::OP_PEEK_BACK:
            begin
                rd_addr = last_addr;
                if (empty)
                begin
                    info.status = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en        = accept;
                    info.use_mem = 1'b1;
                    if (func == dq_pkg::OP_POP_BACK)
                    begin
                        occ_next = occ_reg - CW'(1);
                    end
                end
            end
            dq_pkg::OP_SIZE:
            begin
                info.imm_data = dq_pkg::WORD_W'(occ_reg);
            end
            dq_pkg::OP_CLEAR:
            begin
                head_next = tail_addr;
                occ_next  = '0;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    assign count_next = occ_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            occ_reg  <= '0;
        end
        else if (accept)
        begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
        end
    end

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= DEPTH_C)
        else $error("occupancy beyond depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= LAST_A)
        else $error("head index beyond last entry");

    a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("write and read issued for one item");
`endif

endmodule

FILE: tb/tb_double_ended_queue_core.sv
module tb_double_ended_queue_core;

    // block built at its default depth, so the full case needs a long fill run
    localparam int DEPTH = dq_pkg::DEPTH_DEF;
    localparam int CW    = $clog2(DEPTH + 1);

    // shapes of the random traffic
    // low: hovers near empty, full: sits at the top
    typedef enum int {
        PH_LOW,
        PH_FILL,
        PH_FULL
    } phase_t;

    // one result item as the block should return it
    typedef struct {
        dq_pkg::status_t            st;
        logic [dq_pkg::WORD_W-1:0]  dat;
        logic [CW-1:0]              cnt;
    } dq_result_t;

    // one row of the directed table
    typedef struct {
        dq_pkg::op_t                op;
        logic [dq_pkg::WORD_W-1:0]  word;
        bit                         typed;
        dq_pkg::status_t            st;
        logic [dq_pkg::WORD_W-1:0]  dat;
        int                         cnt;
    } plan_row_t;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic [2:0]                         func;
    logic signed [dq_pkg::WORD_W-1:0]   value;
    logic                               out_valid;
    logic                               out_ready;
    logic [1:0]                         status;
    logic signed [dq_pkg::WORD_W-1:0]   data;
    logic [CW-1:0]                      count;

    // expectation typed in the table, travels alongside the item
    bit                         req_typed;
    dq_result_t                 req_expect;

    // own copy of the ring: stored words, front position, occupancy
    logic [dq_pkg::WORD_W-1:0]  ring_mem [DEPTH];
    int                         head_pos   = 0;
    int                         fill_level = 0;

    // results still owed by the block, oldest first
    dq_result_t                 owed_results [$];

    // run bookkeeping
    int                         error_count   = 0;
    int                         items_taken   = 0;
    int                         results_seen  = 0;
    int                         full_hits     = 0;
    int                         empty_hits    = 0;
    int                         peak_fill     = 0;
    bit                         in_calm       = 1'b0;
    bit                         out_calm      = 1'b0;

    double_ended_queue_core #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .value(value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .data(data),
        .count(count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // generous ceiling on the whole run
    initial
    begin
        #2_000_000;
        $display("timeout: %0d results still owed", owed_results.size());
        $display("** double_ended_queue_core: FAILED **");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // ring behaviour for one request; updates the local copy
    task automatic apply_request(input dq_pkg::op_t op,
                                 input logic [dq_pkg::WORD_W-1:0] word,
                                 output dq_result_t res);
        res.st  = dq_pkg::ST_OK;
        res.dat = '0;
        case (op)
            dq_pkg::OP_PUSH_BACK, dq_pkg::OP_PUSH_FRONT:
            begin
                if (fill_level >= DEPTH)
                begin
                    // full: word dropped
                    res.st = dq_pkg::ST_FULL;
                end
                else if (op == dq_pkg::OP_PUSH_BACK)
                begin
                    ring_mem[(head_pos + fill_level) % DEPTH] = word;
                    fill_level++;
                end
                else
                begin
                    // front steps back and wraps below zero
                    head_pos = (head_pos + DEPTH - 1) % DEPTH;
                    ring_mem[head_pos] = word;
                    fill_level++;
                end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_PEEK_FRONT:
            begin
                if (fill_level == 0)
                begin
                    res.st = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    res.dat = ring_mem[head_pos];
                    if (op == dq_pkg::OP_POP_FRONT)
                    begin
                        head_pos = (head_pos + 1) % DEPTH;
                        fill_level--;
                    end
                end
            end
            dq_pkg::OP_POP_BACK, dq_pkg::OP_PEEK_BACK:
            begin
                if (fill_level == 0)
                begin
                    res.st = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    res.dat = ring_mem[(head_pos + fill_level - 1) % DEPTH];
                    if (op == dq_pkg::OP_POP_BACK)
                    begin
                        fill_level--;
                    end
                end
            end
            dq_pkg::OP_SIZE:
            begin
                res.dat = fill_level;
            end
            default:
            begin
                // clear: front moves past every stored word
                head_pos   = (head_pos + fill_level) % DEPTH;
                fill_level = 0;
            end
        endcase
        res.cnt = CW'(fill_level);
    endtask

    // wait cycles before the next item on either side
    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    // mostly random words, now and then an extreme
    function automatic logic [dq_pkg::WORD_W-1:0] random_word();
        logic [dq_pkg::WORD_W-1:0] w;
        case ($urandom_range(0, 7))
            0:       w = 32'h7FFF_FFFF;
            1:       w = 32'h8000_0000;
            2:       w = 32'h0000_0000;
            3:       w = 32'hFFFF_FFFF;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    function automatic dq_pkg::op_t pick_op(input phase_t ph);
        int          r;
        dq_pkg::op_t pick;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL:
            begin
                // nearly all pushes so the ring climbs to full
                if (r < 47)      pick = dq_pkg::OP_PUSH_BACK;
                else if (r < 94) pick = dq_pkg::OP_PUSH_FRONT;
                else if (r < 95) pick = dq_pkg::OP_POP_FRONT;
                else if (r < 96) pick = dq_pkg::OP_POP_BACK;
                else if (r < 97) pick = dq_pkg::OP_PEEK_FRONT;
                else if (r < 98) pick = dq_pkg::OP_PEEK_BACK;
                else             pick = dq_pkg::OP_SIZE;
            end
            PH_FULL:
            begin
                // half pushes: most bounce off the full ring
                if (r < 25)      pick = dq_pkg::OP_PUSH_BACK;
                else if (r < 50) pick = dq_pkg::OP_PUSH_FRONT;
                else if (r < 60) pick = dq_pkg::OP_POP_FRONT;
                else if (r < 70) pick = dq_pkg::OP_POP_BACK;
                else if (r < 80) pick = dq_pkg::OP_PEEK_FRONT;
                else if (r < 90) pick = dq_pkg::OP_PEEK_BACK;
                else             pick = dq_pkg::OP_SIZE;
            end
            default:
            begin
                // balanced, so empty errors and clears turn up often
                if (r < 20)      pick = dq_pkg::OP_PUSH_BACK;
                else if (r < 40) pick = dq_pkg::OP_PUSH_FRONT;
                else if (r < 55) pick = dq_pkg::OP_POP_FRONT;
                else if (r < 70) pick = dq_pkg::OP_POP_BACK;
                else if (r < 78) pick = dq_pkg::OP_PEEK_FRONT;
                else if (r < 85) pick = dq_pkg::OP_PEEK_BACK;
                else if (r < 93) pick = dq_pkg::OP_SIZE;
                else             pick = dq_pkg::OP_CLEAR;
            end
        endcase
        return pick;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic drive_request(input dq_pkg::op_t op,
                                 input logic [dq_pkg::WORD_W-1:0] word,
                                 input bit typed, input dq_result_t want);
        int gap;
        if ($urandom_range(0, 39) == 0)
        begin
            in_calm = !in_calm;
        end
        gap = draw_gap(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= op;
        value      <= word;
        req_typed  <= typed;
        req_expect <= want;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // predict on every accepted request, then check any result taken this edge
    always @(posedge clk)
    begin : scoreboard
        dq_result_t predicted;
        dq_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                apply_request(dq_pkg::op_t'(func), value, predicted);
                items_taken++;
                if (predicted.st == dq_pkg::ST_FULL)
                begin
                    full_hits++;
                end
                if (predicted.st == dq_pkg::ST_EMPTY)
                begin
                    empty_hits++;
                end
                if (fill_level > peak_fill)
                begin
                    peak_fill = fill_level;
                end
                owed_results.insert(owed_results.size(),
                                    req_typed ? req_expect : predicted);
            end
            if (out_valid && out_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    flag_mismatch($sformatf("result with nothing owed: status %0d data %h",
                                            status, data));
                end
                else
                begin
                    want = owed_results[0];
                    owed_results.delete(0);
                    results_seen++;
                    if (status !== want.st)
                    begin
                        flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                                results_seen, status, want.st));
                    end
                    if (data !== want.dat)
                    begin
                        flag_mismatch($sformatf("result %0d data %h, want %h",
                                                results_seen, data, want.dat));
                    end
                    if (count !== want.cnt)
                    begin
                        flag_mismatch($sformatf("result %0d count %0d, want %0d",
                                                results_seen, count, want.cnt));
                    end
                end
            end
        end
    end

    // result side: random stalls with calm stretches
    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        while (rst_n !== 1'b1)
        begin
            @(negedge clk);
        end
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                out_calm = !out_calm;
            end
            stall = draw_gap(out_calm);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        plan_row_t  plan [23];
        dq_result_t typed_want;
        dq_result_t no_want;
        int         n;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        func       = '0;
        value      = '0;
        req_typed  = 1'b0;
        req_expect = '{dq_pkg::ST_OK, '0, '0};
        no_want    = '{dq_pkg::ST_OK, '0, '0};

        // directed table; pops and peeks carry junk words that must be ignored
        plan = '{
            '{dq_pkg::OP_PEEK_FRONT, 32'h1111_1111, 1'b1, dq_pkg::ST_EMPTY, 32'h0, 0},
            '{dq_pkg::OP_POP_BACK,   32'h2222_2222, 1'b1, dq_pkg::ST_EMPTY, 32'h0, 0},
            '{dq_pkg::OP_SIZE,       32'hFFFF_FFFF, 1'b1, dq_pkg::ST_OK,    32'h0, 0},
            '{dq_pkg::OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, dq_pkg::ST_OK,    32'h0, 1},
            '{dq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1'b1, dq_pkg::ST_OK,    32'h0, 2},
            '{dq_pkg::OP_PEEK_FRONT, 32'h0, 1'b1, dq_pkg::ST_OK, 32'h8000_0000, 2},
            '{dq_pkg::OP_PEEK_BACK,  32'h0, 1'b1, dq_pkg::ST_OK, 32'h7FFF_FFFF, 2},
            '{dq_pkg::OP_SIZE,       32'h0, 1'b1, dq_pkg::ST_OK, 32'h2,         2},
            '{dq_pkg::OP_POP_BACK,   32'h3333_3333, 1'b1, dq_pkg::ST_OK, 32'h7FFF_FFFF, 1},
            '{dq_pkg::OP_POP_FRONT,  32'h4444_4444, 1'b1, dq_pkg::ST_OK, 32'h8000_0000, 0},
            '{dq_pkg::OP_POP_FRONT,  32'h0,         1'b1, dq_pkg::ST_EMPTY, 32'h0, 0},
            '{dq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, dq_pkg::ST_OK,    32'h0, 0},
            '{dq_pkg::OP_PUSH_BACK,  32'h0000_0000, 1'b0, dq_pkg::ST_OK,    32'h0, 0},
            '{dq_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A, 1'b0, dq_pkg::ST_OK,    32'h0, 0},
            '{dq_pkg::OP_PUSH_BACK,  32'hA5A5_A5A5, 1'b0, dq_pkg::ST_OK,    32'h0, 0},
            '{dq_pkg::OP_PEEK_BACK,  32'h0,         1'b0, dq_pkg::ST_OK,    32'h0, 0},
            '{dq_pkg::OP_POP_FRONT,  32'h0,         1'b0, dq_pkg::ST_OK,    32'h0, 0},
            '{dq_pkg::OP_CLEAR,      32'hDEAD_BEEF, 1'b1, dq_pkg::ST_OK,    32'h0, 0},
            '{dq_pkg::OP_PEEK_BACK,  32'h0,         1'b1, dq_pkg::ST_EMPTY, 32'h0, 0},
            '{dq_pkg::OP_PUSH_BACK,  32'h1234_5678, 1'b1, dq_pkg::ST_OK,    32'h0, 1},
            '{dq_pkg::OP_PEEK_FRONT, 32'h0,         1'b0, dq_pkg::ST_OK,    32'h0, 0},
            '{dq_pkg::OP_POP_FRONT,  32'h0,         1'b0, dq_pkg::ST_OK,    32'h0, 0},
            '{dq_pkg::OP_CLEAR,      32'h0,         1'b1, dq_pkg::ST_OK,    32'h0, 0}
        };

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            typed_want = '{plan[i].st, plan[i].dat, CW'(plan[i].cnt)};
            drive_request(plan[i].op, plan[i].word, plan[i].typed, typed_want);
        end

        // near empty: lots of empty errors, clears and wrap of the front
        repeat (50) drive_request(pick_op(PH_LOW), random_word(), 1'b0, no_want);

        // climb to a full ring
        n = 0;
        while (fill_level < DEPTH && n < 4000)
        begin
            drive_request(pick_op(PH_FILL), random_word(), 1'b0, no_want);
            n++;
        end

        // churn at the top, then empty it in one go
        repeat (40) drive_request(pick_op(PH_FULL), random_word(), 1'b0, no_want);
        drive_request(dq_pkg::OP_CLEAR, random_word(), 1'b0, no_want);

        repeat (50) drive_request(pick_op(PH_LOW), random_word(), 1'b0, no_want);
        in_valid <= 1'b0;

        // drain, then allow a few cycles for anything stray
        while (owed_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("requests %0d, results checked %0d, errors %0d", items_taken,
                 results_seen, error_count);
        $display("full rejections %0d, empty rejections %0d, peak occupancy %0d of %0d",
                 full_hits, empty_hits, peak_fill, DEPTH);
        if (error_count == 0)
        begin
            $display("** double_ended_queue_core: PASSED **");
        end
        else
        begin
            $display("** double_ended_queue_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/dq_pkg.sv
hdl/dq_ram.sv
hdl/dq_ctrl.sv
hdl/double_ended_queue_core.sv
tb/tb_double_ended_queue_core.sv
